>>> src/stack_bytecode_alu_executor_assert.svh
// Assertion macros shared by the stack bytecode ALU executor RTL.
// Depends on the asserting module having clk and rst_n in scope.
`ifndef STACK_BYTECODE_ALU_EXECUTOR_ASSERT_SVH
`define STACK_BYTECODE_ALU_EXECUTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sbae_pkg.sv
// Types and constants for the stack bytecode ALU executor.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package sbae_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned POOL_DEPTH_DEF  = 256;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned IMM_W           = 16;
  localparam int unsigned DEPTH_W         = 5;

  typedef enum logic [0:0] {
    REQ_POOL_WR = 1'b0,
    REQ_EXEC    = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_PUSH      = 3'd1,
    OP_ADD       = 3'd2,
    OP_MUL       = 3'd3,
    OP_SHR       = 3'd4,
    OP_MASK_ZEXT = 3'd5,
    OP_MASK_SEXT = 3'd6,
    OP_CLEAR     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_POOL  = 2'd3
  } status_t;

  // Immediate forms. Any form with bit 1 set is a constant pool lookup.
  localparam logic [1:0] FORM_UNSIGNED = 2'd0;
  localparam logic [1:0] FORM_SIGNED   = 2'd1;

  typedef struct packed {
    req_type_t          req_type;
    opcode_t            opcode;
    logic [1:0]         imm_form;
    logic [IMM_W-1:0]   imm_index;
    logic [WORD_W-1:0]  pool_value;
  } sbae_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  top_value;
    logic [DEPTH_W-1:0] depth_now;
    status_t            status;
  } sbae_out_t;

  // Control carried from the accept stage into the execute stage.
  typedef struct packed {
    opcode_t          op;
    logic [1:0]       imm_form;
    logic [IMM_W-1:0] imm_index;
    status_t          status;
    logic             push_ok;
    logic             alu_ok;
    logic             empty_after;
  } exec_ctl_t;

endpackage

>>> src/stack_bytecode_alu_executor.sv
// Stack bytecode ALU executor: top level with stack and constant pool memories.
// Depends on sbae_pkg and stack_bytecode_alu_executor_assert.svh.
`timescale 1ns / 1ps

// One beat in gives one beat out. The block takes a new beat every cycle while the output
// is not stalled, except that a multiply holds the execute stage until its 64-bit product
// is summed, because the product is formed from 32-bit partial products that are
// registered before they are summed; a stream of multiplies therefore cannot be taken back
// to back. A result passes the execute-stage registers and then the output register.
// Stack depth, status and the constant pool write are settled in the accept cycle; the
// operand stack and the constant pool are synchronous memories read in that cycle, and
// the stack entry written back by the execute stage is forwarded to the beat read in the
// same cycle. No clearing pass is needed after reset.
module stack_bytecode_alu_executor
  import sbae_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned POOL_DEPTH  = POOL_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sbae_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sbae_out_t out_data
);

  `include "stack_bytecode_alu_executor_assert.svh"

  localparam int unsigned SA_W   = $clog2(STACK_DEPTH);
  localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PA_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  // Memories.
  logic [WORD_W-1:0] stk_mem  [STACK_DEPTH];
  logic [WORD_W-1:0] pool_mem [POOL_DEPTH];

  // Accept stage.
  logic              in_acc;
  logic              idx_ok;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_dec;
  logic [FILL_W-1:0] a_fill_nxt;
  status_t           a_status;
  logic              a_push_ok;
  logic              a_alu_ok;
  logic [SA_W-1:0]   stk_ra;
  logic [PA_W-1:0]   pool_a;
  logic              pool_we;

  // Execute stage.
  logic              b_valid_r;
  exec_ctl_t         b_ctl_r;
  logic [SA_W-1:0]   b_wa_r;
  logic [FILL_W-1:0] b_fill_r;
  logic [WORD_W-1:0] stk_rd_r;
  logic [WORD_W-1:0] pool_rd_r;
  logic              byp_hit_r;
  logic [WORD_W-1:0] byp_data_r;
  logic              mul_phase_r;
  logic [WORD_W-1:0] pp_ll_r;
  logic [31:0]       pp_lh_r;
  logic [31:0]       pp_hl_r;
  logic              b_is_mul;
  logic              b_done;
  logic              b_adv;
  logic [WORD_W-1:0] b_imm;
  logic [WORD_W-1:0] opnd;
  logic [5:0]        sh;
  logic [5:0]        sign_pos;
  logic              big;
  logic [WORD_W-1:0] low_mask;
  logic [WORD_W-1:0] p_ll;
  logic [31:0]       p_lh;
  logic [31:0]       p_hl;
  logic [31:0]       mid_sum;
  logic [WORD_W-1:0] mul_sum;
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] b_top;
  logic              stk_we;

  // Output register.
  logic              out_valid_r;
  sbae_out_t         out_data_r;

  assign in_acc   = in_valid && in_ready;
  assign idx_ok   = 32'(in_data.imm_index) < POOL_DEPTH;
  assign fill_dec = fill_r - FILL_W'(1);
  assign stk_ra   = fill_dec[SA_W-1:0];
  assign pool_a   = in_data.imm_index[PA_W-1:0];
  assign pool_we  = in_acc && (in_data.req_type == REQ_POOL_WR) && idx_ok;

  // Depth and status depend only on the fill count and the beat, so they resolve here.
  always_comb begin
    a_status   = ST_OK;
    a_fill_nxt = fill_r;
    a_push_ok  = 1'b0;
    a_alu_ok   = 1'b0;
    if (in_data.req_type == REQ_POOL_WR) begin
      if (!idx_ok) begin
        a_status = ST_POOL;
      end
    end else begin
      unique case (in_data.opcode)
        OP_NOP: begin
        end
        OP_CLEAR: begin
          a_fill_nxt = '0;
        end
        default: begin
          if (in_data.opcode == OP_PUSH) begin
            if (32'(fill_r) >= STACK_DEPTH) begin
              a_status = ST_OVER;
            end
          end else if (fill_r == '0) begin
            a_status = ST_UNDER;
          end
          if (a_status == ST_OK && in_data.imm_form[1] && !idx_ok) begin
            a_status = ST_POOL;
          end
          if (a_status == ST_OK) begin
            if (in_data.opcode == OP_PUSH) begin
              a_push_ok  = 1'b1;
              a_fill_nxt = fill_r + FILL_W'(1);
            end else begin
              a_alu_ok = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= a_fill_nxt;
    end
  end

  // Constant pool: written on accept, read on accept.
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_a] <= in_data.pool_value;
    end
    if (in_acc) begin
      pool_rd_r <= pool_mem[pool_a];
    end
  end

  // Operand stack: read of the current top on accept, write back from the execute stage.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[b_wa_r] <= b_top;
    end
    if (in_acc) begin
      stk_rd_r <= stk_mem[stk_ra];
    end
  end

  // The memory returns old data when the execute stage writes the entry being read,
  // so that write is captured here and used instead.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_hit_r  <= stk_we && (b_wa_r == stk_ra);
      byp_data_r <= b_top;
      b_ctl_r.op          <= in_data.opcode;
      b_ctl_r.imm_form    <= in_data.imm_form;
      b_ctl_r.imm_index   <= in_data.imm_index;
      b_ctl_r.status      <= a_status;
      b_ctl_r.push_ok     <= a_push_ok;
      b_ctl_r.alu_ok      <= a_alu_ok;
      b_ctl_r.empty_after <= (a_fill_nxt == '0);
      b_wa_r   <= a_push_ok ? fill_r[SA_W-1:0] : stk_ra;
      b_fill_r <= a_fill_nxt;
    end
  end

  assign b_is_mul = b_ctl_r.alu_ok && (b_ctl_r.op == OP_MUL);
  assign b_done   = !b_is_mul || mul_phase_r;
  assign b_adv    = b_valid_r && b_done && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_adv;
  assign stk_we   = b_adv && (b_ctl_r.push_ok || b_ctl_r.alu_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      mul_phase_r <= 1'b0;
    end else begin
      if (in_acc) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        mul_phase_r <= 1'b0;
      end else if (b_valid_r && b_is_mul) begin
        mul_phase_r <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (b_ctl_r.imm_form)
      FORM_UNSIGNED: b_imm = {{(WORD_W-IMM_W){1'b0}}, b_ctl_r.imm_index};
      FORM_SIGNED:   b_imm = {{(WORD_W-IMM_W){b_ctl_r.imm_index[IMM_W-1]}},
                              b_ctl_r.imm_index};
      // Pool lookup, including the fourth form.
      default:       b_imm = pool_rd_r;
    endcase
  end

  assign opnd     = byp_hit_r ? byp_data_r : stk_rd_r;
  assign sh       = b_imm[5:0];
  assign sign_pos = sh - 6'd1;
  assign big      = |b_imm[WORD_W-1:6];
  assign low_mask = ~({WORD_W{1'b1}} << sh);

  // The low 64 bits of the product are the same for signed and unsigned operands.
  assign p_ll = 64'(opnd[31:0]) * 64'(b_imm[31:0]);
  assign p_lh = opnd[31:0] * b_imm[63:32];
  assign p_hl = opnd[63:32] * b_imm[31:0];

  always_ff @(posedge clk) begin
    if (!mul_phase_r) begin
      pp_ll_r <= p_ll;
      pp_lh_r <= p_lh;
      pp_hl_r <= p_hl;
    end
  end

  assign mid_sum = pp_lh_r + pp_hl_r;
  assign mul_sum = pp_ll_r + {mid_sum, 32'b0};

  always_comb begin
    unique case (b_ctl_r.op)
      OP_ADD: alu = opnd + b_imm;
      OP_MUL: alu = mul_sum;
      OP_SHR: alu = big ? '0 : (opnd >> sh);
      OP_MASK_ZEXT: begin
        if (big) begin
          alu = opnd;
        end else if (sh == 6'd0) begin
          alu = '0;
        end else begin
          alu = opnd & low_mask;
        end
      end
      OP_MASK_SEXT: begin
        if (big) begin
          alu = opnd;
        end else if (sh == 6'd0) begin
          alu = '0;
        end else if (opnd[sign_pos]) begin
          alu = (opnd & low_mask) | ~low_mask;
        end else begin
          alu = opnd & low_mask;
        end
      end
      default: alu = opnd;
    endcase
  end

  always_comb begin
    if (b_ctl_r.empty_after) begin
      b_top = '0;
    end else if (b_ctl_r.push_ok) begin
      b_top = b_imm;
    end else if (b_ctl_r.alu_ok) begin
      b_top = alu;
    end else begin
      b_top = opnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data_r.top_value <= b_top;
      out_data_r.depth_now <= DEPTH_W'(b_fill_r);
      out_data_r.status    <= b_ctl_r.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBAE_ASSERT_NXT(a_push_full_holds,
    in_acc && in_data.req_type == REQ_EXEC && in_data.opcode == OP_PUSH &&
    32'(fill_r) == STACK_DEPTH,
    32'(fill_r) == STACK_DEPTH, "push on a full stack changed the depth")
  `SBAE_ASSERT_NXT(a_clear_empties,
    in_acc && in_data.req_type == REQ_EXEC && in_data.opcode == OP_CLEAR,
    fill_r == '0, "clear did not empty the stack")
  `SBAE_ASSERT_IMP(a_mul_phase_owner, mul_phase_r,
    b_valid_r && b_ctl_r.alu_ok && b_ctl_r.op == OP_MUL,
    "multiply phase set without a multiply in the execute stage")
  `SBAE_ASSERT_IMP(a_under_empty, out_valid_r && out_data_r.status == ST_UNDER,
    out_data_r.depth_now == '0, "underflow reported with a nonempty stack")
  `SBAE_ASSERT_IMP(a_empty_zero_top, out_valid_r && out_data_r.depth_now == '0,
    out_data_r.top_value == '0, "empty stack reported a nonzero top")

endmodule

>>> verif/stack_bytecode_alu_executor_test.sv
// Self-checking testbench for stack_bytecode_alu_executor: directed and random bytecode
// streams, bursty input and stalling output, every result beat checked against a predictor.
// Depends on sbae_pkg and the RTL top level; needs no other file.
`timescale 1ns / 1ps

module stack_bytecode_alu_executor_test;
  import sbae_pkg::*;

  // Any immediate form with bit 1 set reads the constant pool.
  localparam logic [1:0] FORM_POOL     = 2'd2;
  localparam logic [1:0] FORM_POOL_ALT = 2'd3;
  localparam int unsigned RANDOM_BEATS = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sbae_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sbae_out_t out_data;

  stack_bytecode_alu_executor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Predictor state, updated in acceptance order.
  logic [WORD_W-1:0] stack_mirror [STACK_DEPTH_DEF];
  logic [WORD_W-1:0] pool_mirror [POOL_DEPTH_DEF];
  int unsigned       fill_mirror = 0;

  // Stimulus bookkeeping: which pool entries a lookup may legally read.
  bit       pool_seen [POOL_DEPTH_DEF];
  int       written_idx [$];

  sbae_in_t  beats_to_send [$];
  sbae_out_t expected_results [$];
  int        beats_queued = 0;
  int        beats_accepted = 0;
  int        fail_cnt = 0;

  int        burst_left;
  int        gap_left;
  logic [15:0] ready_pattern;
  int unsigned ready_phase;
  sbae_out_t want;

  initial begin
    foreach (stack_mirror[i]) stack_mirror[i] = '0;
    foreach (pool_mirror[i]) pool_mirror[i] = '0;
  end

  function automatic sbae_out_t execute_beat(sbae_in_t beat);
    sbae_out_t   res;
    status_t     st;
    logic [63:0] imm;
    logic [63:0] v;
    logic        pool_bad;
    st = ST_OK;
    imm = '0;
    pool_bad = 1'b0;
    if (beat.req_type == REQ_POOL_WR) begin
      if (beat.imm_index < POOL_DEPTH_DEF) pool_mirror[beat.imm_index] = beat.pool_value;
      else st = ST_POOL;
    end else if (beat.opcode == OP_CLEAR) begin
      fill_mirror = 0;
    end else if (beat.opcode != OP_NOP) begin
      if (beat.opcode == OP_PUSH) begin
        if (fill_mirror >= STACK_DEPTH_DEF) st = ST_OVER;
      end else if (fill_mirror == 0) begin
        st = ST_UNDER;
      end
      if (beat.imm_form[1]) begin
        if (beat.imm_index < POOL_DEPTH_DEF) imm = pool_mirror[beat.imm_index];
        else pool_bad = 1'b1;
      end else if (beat.imm_form == FORM_SIGNED) begin
        imm = {{48{beat.imm_index[15]}}, beat.imm_index};
      end else begin
        imm = {48'd0, beat.imm_index};
      end
      // A stack error hides a bad pool index.
      if (st == ST_OK && pool_bad) st = ST_POOL;
      if (st == ST_OK) begin
        if (beat.opcode == OP_PUSH) begin
          stack_mirror[fill_mirror] = imm;
          fill_mirror++;
        end else begin
          v = stack_mirror[fill_mirror - 1];
          case (beat.opcode)
            OP_ADD: v = v + imm;
            OP_MUL: v = v * imm;
            OP_SHR: v = (imm >= 64) ? '0 : v >> imm;
            default: begin
              if (imm == 0) begin
                v = '0;
              end else if (imm < 64) begin
                v = v & (~64'd0 >> (64 - imm));
                if (beat.opcode == OP_MASK_SEXT && v[imm - 1]) v = v | (~64'd0 << imm);
              end
            end
          endcase
          stack_mirror[fill_mirror - 1] = v;
        end
      end
    end
    res.top_value = (fill_mirror > 0) ? stack_mirror[fill_mirror - 1] : '0;
    res.depth_now = fill_mirror[DEPTH_W-1:0];
    res.status = st;
    return res;
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 72));
      1: return 64'h8000_0000_0000_0000;
      2: return ~64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Lookups that use the immediate never touch a pool entry that has not been written.
  task automatic queue_item(sbae_in_t beat);
    if (beat.req_type == REQ_EXEC && beat.opcode != OP_NOP && beat.opcode != OP_CLEAR &&
        beat.imm_form[1] && beat.imm_index < POOL_DEPTH_DEF && !pool_seen[beat.imm_index])
      beat.imm_index = 16'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    if (beat.req_type == REQ_POOL_WR && beat.imm_index < POOL_DEPTH_DEF &&
        !pool_seen[beat.imm_index]) begin
      pool_seen[beat.imm_index] = 1'b1;
      written_idx = {written_idx, int'(beat.imm_index)};
    end
    beats_to_send = {beats_to_send, beat};
    beats_queued++;
  endtask

  task automatic queue_pool_write(logic [15:0] idx, logic [63:0] value);
    sbae_in_t beat;
    beat.req_type = REQ_POOL_WR;
    beat.opcode = opcode_t'($urandom_range(OP_NOP, OP_CLEAR));
    beat.imm_form = 2'($urandom);
    beat.imm_index = idx;
    beat.pool_value = value;
    queue_item(beat);
  endtask

  task automatic queue_exec(opcode_t op, logic [1:0] form, logic [15:0] idx);
    sbae_in_t beat;
    beat.req_type = REQ_EXEC;
    beat.opcode = op;
    beat.imm_form = form;
    beat.imm_index = idx;
    beat.pool_value = random_word();
    queue_item(beat);
  endtask

  task automatic queue_random_exec(opcode_t op);
    logic [1:0]  form;
    logic [15:0] idx;
    form = 2'($urandom_range(0, 3));
    if (form[1]) begin
      idx = ($urandom_range(0, 7) == 0) ? 16'($urandom)
          : 16'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    end else if (op >= OP_SHR && op <= OP_MASK_SEXT && $urandom_range(0, 3) != 0) begin
      idx = 16'($urandom_range(0, 70));
    end else begin
      idx = 16'($urandom);
    end
    queue_exec(op, form, idx);
  endtask

  // A well-formed program: optional pool writes, usually a clear, pushes, then ALU work.
  task automatic run_program(int n_push);
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) begin
        queue_pool_write(($urandom_range(0, 7) == 0) ? 16'($urandom_range(POOL_DEPTH_DEF, 65535))
                         : 16'($urandom_range(0, POOL_DEPTH_DEF - 1)), random_word());
      end
    end
    if ($urandom_range(0, 3) != 0) queue_random_exec(OP_CLEAR);
    repeat (n_push) queue_random_exec(OP_PUSH);
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) == 0) queue_random_exec(OP_NOP);
      else queue_random_exec(opcode_t'($urandom_range(OP_ADD, OP_MASK_SEXT)));
    end
  endtask

  initial begin
    int directed_cnt;
    sbae_in_t noise;

    queue_pool_write(16'd0, ~64'd0);
    queue_pool_write(16'd255, 64'h8000_0000_0000_0000);
    queue_pool_write(16'd1, 64'd64);
    queue_pool_write(16'(POOL_DEPTH_DEF), random_word());
    queue_pool_write(16'hFFFF, random_word());
    queue_exec(OP_NOP, FORM_POOL_ALT, 16'hFFFF);
    queue_exec(OP_CLEAR, FORM_POOL_ALT, 16'hFFFF);
    queue_exec(OP_ADD, FORM_UNSIGNED, 16'd1);
    queue_exec(OP_MASK_SEXT, FORM_POOL, 16'd9999);
    queue_exec(OP_PUSH, FORM_POOL, 16'd300);
    queue_exec(OP_PUSH, FORM_UNSIGNED, 16'hFFFF);
    queue_exec(OP_PUSH, FORM_SIGNED, 16'h8000);
    queue_exec(OP_MUL, FORM_POOL, 16'd255);
    queue_exec(OP_ADD, FORM_SIGNED, 16'hFFFF);
    queue_exec(OP_SHR, FORM_POOL, 16'd1);
    queue_exec(OP_PUSH, FORM_POOL_ALT, 16'd0);
    queue_exec(OP_SHR, FORM_UNSIGNED, 16'd63);
    queue_exec(OP_ADD, FORM_POOL, 16'd512);
    queue_exec(OP_MASK_ZEXT, FORM_UNSIGNED, 16'd0);
    queue_exec(OP_PUSH, FORM_POOL, 16'd0);
    queue_exec(OP_MASK_SEXT, FORM_UNSIGNED, 16'd1);
    queue_exec(OP_MASK_ZEXT, FORM_POOL, 16'd1);
    queue_exec(OP_MASK_SEXT, FORM_UNSIGNED, 16'd200);
    queue_exec(OP_MASK_ZEXT, FORM_UNSIGNED, 16'd32);
    queue_exec(OP_CLEAR, FORM_UNSIGNED, 16'd0);
    directed_cnt = beats_queued;

    // The first program runs the stack past full, so overflow is reached unless a push fails.
    run_program(STACK_DEPTH_DEF + 1);
    while (beats_queued < directed_cnt + RANDOM_BEATS) begin
      if ($urandom_range(0, 6) == 0) begin
        noise.req_type = req_type_t'($urandom_range(0, 1));
        noise.opcode = opcode_t'($urandom_range(OP_NOP, OP_CLEAR));
        noise.imm_form = 2'($urandom);
        noise.imm_index = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
        noise.pool_value = random_word();
        queue_item(noise);
      end else begin
        run_program(($urandom_range(0, 4) == 0) ? $urandom_range(12, STACK_DEPTH_DEF + 2)
                                                : $urandom_range(0, 6));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_accepted != beats_queued) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps, some of them zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results = {expected_results, execute_beat(in_data)};
        beats_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= beats_to_send.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a repeating ready pattern from a 16-bit word, redrawn, sometimes never stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_pattern = 16'hFFFF;
      ready_phase = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result beat: top=%h depth=%0d status=%0d",
                     out_data.top_value, out_data.depth_now, out_data.status);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.top_value !== want.top_value || out_data.depth_now !== want.depth_now ||
              out_data.status !== want.status) begin
            if (fail_cnt < 10)
              $display("result mismatch: top %h (exp %h) depth %0d (exp %0d) status %0d (exp %0d)",
                       out_data.top_value, want.top_value, out_data.depth_now, want.depth_now,
                       out_data.status, want.status);
            fail_cnt++;
          end
        end
      end
      ready_phase++;
      if (ready_phase % 64 == 0) begin
        if ($urandom_range(0, 3) == 0) ready_pattern = 16'hFFFF;
        else ready_pattern = 16'($urandom) | 16'h0001;
      end
      out_ready <= ready_pattern[ready_phase % 16];
    end
  end

endmodule
